### rtl/ppr_pkg.sv
// Package for the pixel prediction residual block.
// Shared constants and configuration register indexes; no dependencies.
`default_nettype none
package ppr_pkg;

  localparam int PIXEL_BITS   = 8;
  localparam int PIXEL_MAX    = 255;
  localparam int VALUE_BITS   = 9;
  localparam int WIDTH_BITS   = 13;
  localparam int HEIGHT_BITS  = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int MAX_WIDTH_DEFAULT = 4096;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DIRECTION      = 2'd0,
    CFG_PREDICTOR_MODE = 2'd1,
    CFG_IMAGE_WIDTH    = 2'd2,
    CFG_IMAGE_HEIGHT   = 2'd3
  } cfg_index_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } direction_t;

  typedef enum logic {
    PRED_LEFT   = 1'b0,
    PRED_MEDIAN = 1'b1
  } predictor_t;

endpackage
`default_nettype wire

### rtl/ppr_predict.sv
// Predictor and residual datapath: median or left prediction, encode/decode.
// Depends on ppr_pkg.
`default_nettype none
module ppr_predict (
  input  wire ppr_pkg::direction_t                direction,
  input  wire ppr_pkg::predictor_t                predictor_mode,
  input  wire logic signed [ppr_pkg::VALUE_BITS-1:0] value_in,
  input  wire logic [ppr_pkg::PIXEL_BITS-1:0]     left,
  input  wire logic [ppr_pkg::PIXEL_BITS-1:0]     top,
  input  wire logic [ppr_pkg::PIXEL_BITS-1:0]     top_left,
  output logic [ppr_pkg::PIXEL_BITS-1:0]          pixel,
  output logic signed [ppr_pkg::VALUE_BITS-1:0]   result
);

  localparam int PB = ppr_pkg::PIXEL_BITS;
  localparam int GB = PB + 3;
  localparam int SB = ppr_pkg::VALUE_BITS + 1;

  logic signed [GB-1:0] a, b, c, mn_ab, mx_ab, mn_mx_c, med;
  logic [PB-1:0]        pred;
  logic signed [SB-1:0] sum;
  logic [PB-1:0]        enc_pixel, dec_pixel;

  always_comb begin
    a = $signed({3'b000, left});
    b = $signed({3'b000, top});
    c = a + b - $signed({3'b000, top_left});
    mn_ab   = (a < b) ? a : b;
    mx_ab   = (a > b) ? a : b;
    mn_mx_c = (mx_ab < c) ? mx_ab : c;
    med     = (mn_ab > mn_mx_c) ? mn_ab : mn_mx_c;
    pred = (predictor_mode == ppr_pkg::PRED_LEFT) ? left : med[PB-1:0];

    enc_pixel = value_in[ppr_pkg::VALUE_BITS-1] ? '0 : value_in[PB-1:0];

    sum = $signed({{(SB-PB){1'b0}}, pred}) + SB'(value_in);
    if (sum < 0) begin
      dec_pixel = '0;
    end else if (sum > SB'(ppr_pkg::PIXEL_MAX)) begin
      dec_pixel = PB'(ppr_pkg::PIXEL_MAX);
    end else begin
      dec_pixel = sum[PB-1:0];
    end

    if (direction == ppr_pkg::DIR_ENCODE) begin
      pixel  = enc_pixel;
      result = $signed({1'b0, enc_pixel}) - $signed({1'b0, pred});
    end else begin
      pixel  = dec_pixel;
      result = $signed({1'b0, dec_pixel});
    end
  end

endmodule
`default_nettype wire

### rtl/pixel_prediction_residual_top.sv
// Pixel prediction residual top level: line store, counters, output buffer.
// Depends on ppr_pkg and ppr_predict.
//
// Takes one item per clock cycle while sample_stall is low and returns one result
// per item, each registered into the output buffer. The previous row sits in a
// one-port-per-direction line store with a registered read; it is read every
// cycle at the column of the next item, and a same-cycle write to that column
// is forwarded. A two-entry output buffer takes one more item while the output
// stalls; sample_stall is the second entry's valid, so the input stalls from
// the cycle after both entries fill until a result leaves.
`default_nettype none
module pixel_prediction_residual_top #(
  parameter int MAX_WIDTH = ppr_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  sample_valid,
  output logic                                       sample_stall,
  input  wire logic signed [ppr_pkg::VALUE_BITS-1:0] value_in,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic signed [ppr_pkg::VALUE_BITS-1:0]      value_out,
  output logic                                       end_of_row,
  output logic                                       end_of_frame,
  input  wire logic                                  cfg_write,
  input  wire logic [ppr_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [ppr_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int PB = ppr_pkg::PIXEL_BITS;
  localparam int VB = ppr_pkg::VALUE_BITS;
  localparam int HB = ppr_pkg::HEIGHT_BITS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = (WW > ppr_pkg::WIDTH_BITS) ? WW : ppr_pkg::WIDTH_BITS;

  ppr_pkg::direction_t direction;
  ppr_pkg::predictor_t predictor_mode;
  logic [ppr_pkg::WIDTH_BITS-1:0] image_width;
  logic [HB-1:0]                  image_height;

  logic [PB-1:0] line_mem [MAX_WIDTH];
  logic [PB-1:0] rd_data;
  logic          bypass;
  logic [PB-1:0] bypass_data;

  logic [PB-1:0] left_pixel, top_left_pixel;
  logic [CW-1:0] column_count, column_count_next;
  logic [HB-1:0] row_count;

  logic          accept, take;
  logic [LW-1:0] width_ext, last_col;
  logic [HB-1:0] last_row;
  logic          eor, eof;
  logic [PB-1:0] top_raw, left, top, top_left, pixel;
  logic signed [VB-1:0] result;

  logic                 skid_valid;
  logic signed [VB-1:0] skid_value;
  logic                 skid_eor, skid_eof;

  assign accept       = sample_valid && !sample_stall;
  assign take         = result_valid && !result_stall;
  assign sample_stall = skid_valid;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      direction      <= ppr_pkg::DIR_ENCODE;
      predictor_mode <= ppr_pkg::PRED_MEDIAN;
      image_width    <= ppr_pkg::WIDTH_BITS'(4096);
      image_height   <= HB'(1);
    end else if (cfg_write) begin
      case (ppr_pkg::cfg_index_t'(cfg_index))
        ppr_pkg::CFG_DIRECTION:      direction <= ppr_pkg::direction_t'(cfg_data[0]);
        ppr_pkg::CFG_PREDICTOR_MODE: predictor_mode <= ppr_pkg::predictor_t'(cfg_data[0]);
        ppr_pkg::CFG_IMAGE_WIDTH:    image_width <= cfg_data[ppr_pkg::WIDTH_BITS-1:0];
        ppr_pkg::CFG_IMAGE_HEIGHT:   image_height <= cfg_data[HB-1:0];
        default: ;
      endcase
    end
  end

  // position and neighbours
  always_comb begin
    width_ext = LW'(image_width);
    if (image_width == '0) begin
      last_col = '0;
    end else if (width_ext > LW'(MAX_WIDTH)) begin
      last_col = LW'(MAX_WIDTH - 1);
    end else begin
      last_col = width_ext - LW'(1);
    end
    last_row = (image_height == '0) ? '0 : image_height - HB'(1);
    eor = LW'(column_count) >= last_col;
    eof = eor && (row_count >= last_row);

    top_raw  = bypass ? bypass_data : rd_data;
    left     = (column_count == '0) ? '0 : left_pixel;
    top      = (row_count == '0) ? '0 : top_raw;
    top_left = (row_count == '0 || column_count == '0) ? '0 : top_left_pixel;

    column_count_next = column_count;
    if (accept) begin
      column_count_next = eor ? '0 : column_count + CW'(1);
    end
  end

  ppr_predict u_predict (
    .direction      (direction),
    .predictor_mode (predictor_mode),
    .value_in       (value_in),
    .left           (left),
    .top            (top),
    .top_left       (top_left),
    .pixel          (pixel),
    .result         (result)
  );

  // line store: read ahead at the next column, write the finished pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[column_count] <= pixel;
    end
    rd_data     <= line_mem[column_count_next];
    bypass_data <= pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass         <= 1'b0;
      column_count   <= '0;
      row_count      <= '0;
      left_pixel     <= '0;
      top_left_pixel <= '0;
    end else begin
      bypass       <= accept && (column_count_next == column_count);
      column_count <= column_count_next;
      if (accept) begin
        left_pixel     <= pixel;
        top_left_pixel <= top;
        if (eor) begin
          row_count <= eof ? '0 : row_count + HB'(1);
        end
      end
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (accept) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        value_out    <= skid_value;
        end_of_row   <= skid_eor;
        end_of_frame <= skid_eof;
      end
    end else if (accept) begin
      if (!result_valid || take) begin
        value_out    <= result;
        end_of_row   <= eor;
        end_of_frame <= eof;
      end else begin
        skid_value <= result;
        skid_eor   <= eor;
        skid_eof   <= eof;
      end
    end
  end

endmodule
`default_nettype wire

### tb/pixel_prediction_residual_top_tb.sv
// Self-checking testbench for pixel_prediction_residual_top: directed table, then random
// frames in both directions, checked against an in-bench median/left pixel predictor.
// Depends on ppr_pkg and the RTL of pixel_prediction_residual_top.
module pixel_prediction_residual_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH   = ppr_pkg::MAX_WIDTH_DEFAULT;
  localparam int VB           = ppr_pkg::VALUE_BITS;
  localparam int DB           = ppr_pkg::CFG_DATA_BITS;
  localparam int RANDOM_ITEMS = 1200;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic signed [VB-1:0] value;
    logic                 eor;
    logic                 eof;
  } result_t;

  typedef struct packed {
    bit                  is_cfg;
    ppr_pkg::cfg_index_t idx;
    logic [DB-1:0]       data;
    logic signed [VB-1:0] value;
    bit                  typed;
    result_t             want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [VB-1:0] value_in = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [VB-1:0] value_out;
  logic end_of_row;
  logic end_of_frame;
  logic cfg_write = 1'b0;
  ppr_pkg::cfg_index_t cfg_index = ppr_pkg::CFG_DIRECTION;
  logic [DB-1:0] cfg_data = '0;

  pixel_prediction_residual_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .value_in     (value_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value_out    (value_out),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  ppr_pkg::direction_t    cur_dir = ppr_pkg::DIR_ENCODE;
  ppr_pkg::predictor_t    cur_pred = ppr_pkg::PRED_MEDIAN;
  logic [ppr_pkg::WIDTH_BITS-1:0]  width_setting = 13'd4096;
  logic [ppr_pkg::HEIGHT_BITS-1:0] height_setting = 16'd1;
  bit [ppr_pkg::PIXEL_BITS-1:0]    prev_line [LINE_DEPTH];
  int                     left_px = 0;
  int                     up_left_px = 0;
  int                     col_pos = 0;
  int                     row_pos = 0;
  int                     cols_written = 0;

  result_t pending_results [$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      items_sent = 0;
  bit      stall_burst_req = 1'b0;

  function automatic int width_eff(input logic [ppr_pkg::WIDTH_BITS-1:0] w);
    if (w < 1) return 1;
    if (w > LINE_DEPTH) return LINE_DEPTH;
    return int'(w);
  endfunction

  function automatic int clamp_px(input int v);
    if (v < 0) return 0;
    if (v > ppr_pkg::PIXEL_MAX) return ppr_pkg::PIXEL_MAX;
    return v;
  endfunction

  function automatic result_t code_pixel(input logic signed [VB-1:0] v);
    int w, h, c, raw, lft, up, upleft, lo, hi, grad, mid, guess, px, res;
    bit eor, eof;
    result_t r;
    w = width_eff(width_setting);
    h = (height_setting < 1) ? 1 : int'(height_setting);
    c = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
    raw = v;
    lft = (c == 0) ? 0 : left_px;
    up = (row_pos == 0) ? 0 : prev_line[c];
    upleft = (row_pos == 0 || c == 0) ? 0 : up_left_px;
    if (cur_pred == ppr_pkg::PRED_LEFT) begin
      guess = lft;
    end else begin
      lo = (lft < up) ? lft : up;
      hi = (lft < up) ? up : lft;
      grad = lft + up - upleft;
      mid = (hi < grad) ? hi : grad;
      guess = (lo > mid) ? lo : mid;
    end
    if (cur_dir == ppr_pkg::DIR_ENCODE) begin
      px = clamp_px(raw);
      res = px - guess;
    end else begin
      px = clamp_px(guess + raw);
      res = px;
    end
    up_left_px = up;
    prev_line[c] = px[ppr_pkg::PIXEL_BITS-1:0];
    left_px = px;
    if (c + 1 > cols_written) cols_written = c + 1;
    eor = (c >= w - 1);
    eof = eor && (row_pos >= h - 1);
    if (eor) begin
      col_pos = 0;
      row_pos = eof ? 0 : ((row_pos + 1) & 16'hFFFF);
    end else begin
      col_pos = c + 1;
    end
    r.value = res[VB-1:0];
    r.eor = eor;
    r.eof = eof;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic signed [VB-1:0] v);
    stim_row_t s;
    s = '0;
    s.value = v;
    return s;
  endfunction

  function automatic stim_row_t typed_row(input logic signed [VB-1:0] v,
                                          input logic signed [VB-1:0] out,
                                          input bit eor, input bit eof);
    stim_row_t s;
    s = '0;
    s.value = v;
    s.typed = 1'b1;
    s.want = '{value: out, eor: eor, eof: eof};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(input ppr_pkg::cfg_index_t idx,
                                        input logic [DB-1:0] data);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at result %0d", what, got, want, results_seen);
    mismatches++;
  endtask

  task automatic send_item(input logic signed [VB-1:0] v, input bit typed,
                           input result_t want);
    result_t predicted;
    bit calm;
    calm = (items_sent >= 500 && items_sent < 700);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 7) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    value_in <= v;
    do @(posedge clk); while (sample_stall);
    predicted = code_pixel(v);
    pending_results = {pending_results, (typed ? want : predicted)};
    items_sent++;
  endtask

  // every item yields one result, so an empty queue means the block is idle
  task automatic drain();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input ppr_pkg::cfg_index_t idx, input logic [DB-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      ppr_pkg::CFG_DIRECTION:      cur_dir = ppr_pkg::direction_t'(data[0]);
      ppr_pkg::CFG_PREDICTOR_MODE: cur_pred = ppr_pkg::predictor_t'(data[0]);
      ppr_pkg::CFG_IMAGE_WIDTH:    width_setting = data[ppr_pkg::WIDTH_BITS-1:0];
      ppr_pkg::CFG_IMAGE_HEIGHT:   height_setting = data[ppr_pkg::HEIGHT_BITS-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, value_out", value_out, 0);
      end else begin
        want = pending_results.pop_front();
        if (value_out !== want.value) report_mismatch("value_out", value_out, want.value);
        if (end_of_row !== want.eor) report_mismatch("end_of_row", end_of_row, want.eor);
        if (end_of_frame !== want.eof) report_mismatch("end_of_frame", end_of_frame, want.eof);
      end
    end
  end

  initial begin : receiver
    int hold;
    hold = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (stall_burst_req) begin
        stall_burst_req = 1'b0;
        hold = 80;
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else if (results_seen >= 500 && results_seen < 700) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < 7);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("pixel_prediction_residual_top test failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t directed_rows [$];
    logic [31:0] rnd;
    logic [DB-1:0] wd;
    logic signed [VB-1:0] v;
    int random_sent, n, pick;
    bit burst_done;
    random_sent = 0;
    burst_done = 1'b0;

    // reset state: encode, median, width 4096, height 1
    directed_rows = '{
      typed_row(9'sd0, 9'sd0, 1'b0, 1'b0),
      typed_row(9'sd255, 9'sd255, 1'b0, 1'b0),
      typed_row(-9'sd1, -9'sd255, 1'b0, 1'b0),    // negative pixel counts as zero
      typed_row(-9'sd256, 9'sd0, 1'b0, 1'b0),
      cfg_row(ppr_pkg::CFG_IMAGE_WIDTH, 16'd3),   // column already past the new row end
      typed_row(9'sd100, 9'sd100, 1'b1, 1'b1),
      cfg_row(ppr_pkg::CFG_IMAGE_HEIGHT, 16'd3),
      item_row(9'sd10), item_row(9'sd200), item_row(9'sd30),
      item_row(9'sd0), item_row(9'sd128), item_row(9'sd255),
      item_row(9'sd255), item_row(9'sd0), item_row(9'sd254),
      cfg_row(ppr_pkg::CFG_PREDICTOR_MODE, 16'(ppr_pkg::PRED_LEFT)),
      item_row(9'sd50), item_row(9'sd255),
      cfg_row(ppr_pkg::CFG_DIRECTION, 16'(ppr_pkg::DIR_DECODE)),
      cfg_row(ppr_pkg::CFG_PREDICTOR_MODE, 16'(ppr_pkg::PRED_MEDIAN)),
      item_row(9'sd255), item_row(-9'sd256), item_row(9'sd255),
      item_row(-9'sd256), item_row(9'sd1), item_row(-9'sd1),
      cfg_row(ppr_pkg::CFG_IMAGE_WIDTH, 16'd0),   // saturates to one pixel
      cfg_row(ppr_pkg::CFG_IMAGE_HEIGHT, 16'd0),  // treated as one row
      item_row(-9'sd3),
      typed_row(9'sd7, 9'sd7, 1'b1, 1'b1),
      cfg_row(ppr_pkg::CFG_IMAGE_WIDTH, 16'hFFFF), // saturates to the line store size
      cfg_row(ppr_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF),
      cfg_row(ppr_pkg::CFG_DIRECTION, {15'h7FFF, ppr_pkg::DIR_ENCODE}),
      cfg_row(ppr_pkg::CFG_PREDICTOR_MODE, {15'h2AAA, ppr_pkg::PRED_MEDIAN}),
      item_row(9'sd255), item_row(9'sd0)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_item(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 1)) write_reg(ppr_pkg::CFG_DIRECTION, 16'($urandom()));
      if ($urandom_range(0, 1)) write_reg(ppr_pkg::CFG_PREDICTOR_MODE, 16'($urandom()));
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) wd = 16'($urandom_range(1, 8));
        else if (pick < 88) wd = 16'($urandom_range(9, 64));
        else if (pick < 92) wd = 16'd0;
        else if (pick < 96) wd = 16'd4096;
        else wd = 16'($urandom_range(4097, 8191));
        if ($urandom_range(0, 9) == 0) wd[15:13] = 3'($urandom());
        // never grow past the written part of the line store inside a frame
        if (row_pos == 0 || width_eff(wd[ppr_pkg::WIDTH_BITS-1:0]) <= cols_written)
          write_reg(ppr_pkg::CFG_IMAGE_WIDTH, wd);
      end
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) wd = 16'($urandom_range(1, 6));
        else if (pick < 90) wd = 16'd0;
        else if (pick < 95) wd = 16'hFFFF;
        else wd = 16'($urandom());
        write_reg(ppr_pkg::CFG_IMAGE_HEIGHT, wd);
      end
      n = $urandom_range(10, 60);
      if (!burst_done && random_sent >= 150) begin
        n = 120;
        burst_done = 1'b1;
        stall_burst_req = 1'b1;
      end
      repeat (n) begin
        rnd = $urandom();
        if (cur_dir == ppr_pkg::DIR_ENCODE)
          v = ($urandom_range(0, 9) == 0) ? rnd[VB-1:0] : 9'($urandom_range(0, 255));
        else
          v = ($urandom_range(0, 9) < 3) ? rnd[VB-1:0]
                                         : 9'($signed($urandom_range(0, 40)) - 20);
        send_item(v, 1'b0, '0);
        random_sent++;
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("pixel_prediction_residual_top test passed");
    end else begin
      $display("pixel_prediction_residual_top test failed");
    end
    $finish;
  end

endmodule
